// ===== rtl/core/charge_population_stability_check_defines.svh =====
// Assertion macros shared by the charge population stability check RTL.
`ifndef CHARGE_POPULATION_STABILITY_CHECK_DEFINES_SVH
`define CHARGE_POPULATION_STABILITY_CHECK_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CPSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define CPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/cpsc_pkg.sv =====
// Package with types and constants of the charge population stability check.
package cpsc_pkg;

    localparam int MAX_SITES_DEF = 32;
    localparam int POT_W         = 26;
    localparam int LP_W          = 32;
    localparam int ENERGY_W      = 36;
    localparam int LEVEL_W       = 27;
    localparam int TOL_W         = 16;
    localparam int SITES_W       = 6;
    localparam int CFG_W         = 27;
    localparam int CFG_IDX_W     = 2;
    localparam int IDX_IN_W      = 5;
    localparam int CODES_W       = 64;

    localparam logic [SITES_W-1:0] SITES_RST = 6'd32;
    localparam logic signed [LEVEL_W-1:0] NEG_RST = -27'sd5368709;
    localparam logic signed [LEVEL_W-1:0] POS_RST = -27'sd15267267;
    localparam logic [TOL_W-1:0] TOL_RST = 16'd17;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        CH_NEG = 2'd0,
        CH_NEU = 2'd1,
        CH_POS = 2'd2,
        CH_ILL = 2'd3
    } t_charge;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SITES = 2'd0,
        REG_NEG   = 2'd1,
        REG_POS   = 2'd2,
        REG_TOL   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                action;
        logic [IDX_IN_W-1:0] row_site;
        logic [IDX_IN_W-1:0] col_site;
        logic [POT_W-1:0]    pair_potential;
        logic [CODES_W-1:0]  charge_codes;
    } t_request;

    typedef struct packed {
        logic                       states_ok;
        logic                       hop_stable;
        logic                       population_valid;
        logic signed [ENERGY_W-1:0] pair_energy;
    } t_result;

endpackage

// ===== rtl/core/cpsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/charge_population_stability_check.sv =====
// Top level of the charge population stability check.
//
//  channel   direction  handshake               payload
//  request   in         i_start, o_busy         i_req    (cpsc_pkg::t_request)
//  result    out        o_result_valid strobe   o_result (cpsc_pkg::t_result)
//  config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// A matrix write leaves the block ready. An evaluation keeps the block busy:
// one matrix RAM read per cycle, except in the row setup and drain states, first
// for local potentials, then for hop checks; with no site in use it goes straight
// to done. The result follows in the cycle after the block leaves busy.
// Reset is synchronous and active low and leaves the RAM contents alone.
// The result strobe lasts one cycle and cannot be stalled.
`include "charge_population_stability_check_defines.svh"

module charge_population_stability_check #(
    parameter int MAX_SITES = cpsc_pkg::MAX_SITES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  cpsc_pkg::t_request                i_req,
    output logic                              o_result_valid,
    output cpsc_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cpsc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int SITE_W = $clog2(MAX_SITES);
    localparam int CNT_W  = SITE_W + 1;
    localparam int ADDR_W = $clog2(MAX_SITES * MAX_SITES);
    localparam int CHK_W  = cpsc_pkg::ENERGY_W;
    localparam logic [ADDR_W-1:0] MAXA = ADDR_W'(MAX_SITES);

    typedef enum logic [2:0] {
        S_IDLE, S_LP, S_LP_DRAIN, S_HOP_ROW, S_HOP_LATCH, S_HOP, S_HOP_DRAIN, S_DONE
    } t_state;

    t_state r_state;

    logic [cpsc_pkg::SITES_W-1:0]        r_sites;
    logic signed [cpsc_pkg::LEVEL_W-1:0] r_neg;
    logic signed [cpsc_pkg::LEVEL_W-1:0] r_pos;
    logic [cpsc_pkg::TOL_W-1:0]          r_tol;

    logic [cpsc_pkg::CODES_W-1:0] r_codes;
    logic [CNT_W-1:0]             r_n;
    logic [SITE_W-1:0]            r_ci, r_cj;

    logic                           r_lp_vld, r_lp_last;
    logic [SITE_W-1:0]              r_lp_i, r_lp_j;
    logic signed [cpsc_pkg::LP_W-1:0] r_acc;
    logic signed [cpsc_pkg::ENERGY_W-1:0] r_energy;

    logic                           r_chk_vld;
    logic [SITE_W-1:0]              r_chk_i;
    logic signed [cpsc_pkg::LP_W-1:0] r_chk_v;

    logic                           r_hp_vld;
    logic [SITE_W-1:0]              r_hp_i, r_hp_j;
    logic signed [cpsc_pkg::LP_W-1:0] r_vi;

    logic r_states, r_hops;
    logic r_out_vld;
    cpsc_pkg::t_result r_result;

    logic                       mat_we;
    logic [ADDR_W-1:0]          mat_waddr, mat_raddr;
    logic [cpsc_pkg::POT_W-1:0] mat_rdata;
    logic                       lp_we;
    logic [SITE_W-1:0]          lp_raddr;
    logic [cpsc_pkg::LP_W-1:0]  lp_rdata;

    logic [CNT_W-1:0]           nm1;
    logic                       cj_last, ci_last;
    logic [CNT_W-1:0]           n_start;

    logic [1:0]                 lpi_code, lpj_code, chk_code, hpi_code, hpj_code;
    logic signed [cpsc_pkg::LP_W-1:0]     lp_term, lp_sum;
    logic signed [cpsc_pkg::ENERGY_W-1:0] e_term, e_sum;
    logic signed [CHK_W-1:0]    chk_v, chk_a, chk_b, tol_s, mu_s, mup_s;
    logic                       chk_good;
    logic signed [CHK_W-1:0]    hp_vi, hp_vj, hp_diff, hp_de;
    logic                       hp_fail;

    function automatic logic [1:0] code_of(input logic [SITE_W-1:0] k,
                                           input logic [cpsc_pkg::CODES_W-1:0] codes);
        return codes[{k, 1'b0} +: 2];
    endfunction

    cpsc_ram #(
        .WIDTH(cpsc_pkg::POT_W),
        .DEPTH(MAX_SITES * MAX_SITES)
    ) u_mat (
        .i_clk  (i_clk),
        .i_we   (mat_we),
        .i_waddr(mat_waddr),
        .i_wdata(i_req.pair_potential),
        .i_raddr(mat_raddr),
        .o_rdata(mat_rdata)
    );

    cpsc_ram #(
        .WIDTH(cpsc_pkg::LP_W),
        .DEPTH(MAX_SITES)
    ) u_lp (
        .i_clk  (i_clk),
        .i_we   (lp_we),
        .i_waddr(r_lp_i),
        .i_wdata(lp_sum),
        .i_raddr(lp_raddr),
        .o_rdata(lp_rdata)
    );

    always_comb begin
        mat_we = (r_state == S_IDLE) && i_start && (i_req.action == cpsc_pkg::ACT_WRITE)
                 && ({1'b0, i_req.row_site} < 6'(MAX_SITES))
                 && ({1'b0, i_req.col_site} < 6'(MAX_SITES));
        mat_waddr = ADDR_W'(i_req.row_site) * MAXA + ADDR_W'(i_req.col_site);
        if (r_state == S_LP) begin
            mat_raddr = ADDR_W'(r_cj) * MAXA + ADDR_W'(r_ci);
        end else begin
            mat_raddr = ADDR_W'(r_ci) * MAXA + ADDR_W'(r_cj);
        end
        lp_raddr = (r_state == S_HOP_ROW) ? r_ci : r_cj;
        lp_we    = r_lp_vld && r_lp_last;

        nm1     = r_n - CNT_W'(1);
        cj_last = ({1'b0, r_cj} == nm1);
        ci_last = ({1'b0, r_ci} == nm1);
        n_start = (r_sites > 6'(MAX_SITES)) ? CNT_W'(MAX_SITES) : CNT_W'(r_sites);
    end

    always_comb begin
        lpi_code = code_of(r_lp_i, r_codes);
        lpj_code = code_of(r_lp_j, r_codes);
        lp_term  = '0;
        if (r_lp_i != r_lp_j) begin
            if (lpj_code == cpsc_pkg::CH_NEG) begin
                lp_term = -$signed({6'd0, mat_rdata});
            end else if (lpj_code == cpsc_pkg::CH_POS) begin
                lp_term = $signed({6'd0, mat_rdata});
            end
        end
        lp_sum = r_acc + lp_term;

        e_term = '0;
        if (r_lp_j > r_lp_i
            && (lpi_code == cpsc_pkg::CH_NEG || lpi_code == cpsc_pkg::CH_POS)
            && (lpj_code == cpsc_pkg::CH_NEG || lpj_code == cpsc_pkg::CH_POS)) begin
            if (lpi_code == lpj_code) begin
                e_term = $signed({10'd0, mat_rdata});
            end else begin
                e_term = -$signed({10'd0, mat_rdata});
            end
        end
        e_sum = r_energy + e_term;
    end

    always_comb begin
        chk_code = code_of(r_chk_i, r_codes);
        chk_v    = CHK_W'(r_chk_v);
        mu_s     = CHK_W'(r_neg);
        mup_s    = CHK_W'(r_pos);
        tol_s    = $signed({20'd0, r_tol});
        chk_a    = mu_s - chk_v;
        chk_b    = mup_s - chk_v;
        case (chk_code)
            cpsc_pkg::CH_NEG: chk_good = chk_a < tol_s;
            cpsc_pkg::CH_POS: chk_good = chk_b > -tol_s;
            cpsc_pkg::CH_NEU: chk_good = (chk_a > -tol_s) && (chk_b < tol_s);
            default:          chk_good = 1'b0;
        endcase
    end

    always_comb begin
        hpi_code = code_of(r_hp_i, r_codes);
        hpj_code = code_of(r_hp_j, r_codes);
        hp_vi    = CHK_W'(r_vi);
        hp_vj    = CHK_W'($signed(lp_rdata));
        hp_diff  = hp_vi - hp_vj;
        if (hpi_code == cpsc_pkg::CH_NEG) begin
            hp_de = hp_diff - $signed({10'd0, mat_rdata});
        end else begin
            hp_de = -hp_diff - $signed({10'd0, mat_rdata});
        end
        hp_fail = (hpi_code != cpsc_pkg::CH_ILL) && (hpi_code != cpsc_pkg::CH_POS)
                  && (hpj_code != cpsc_pkg::CH_ILL) && (hpj_code > hpi_code)
                  && (hp_de < -$signed({20'd0, r_tol}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sites <= cpsc_pkg::SITES_RST;
            r_neg   <= cpsc_pkg::NEG_RST;
            r_pos   <= cpsc_pkg::POS_RST;
            r_tol   <= cpsc_pkg::TOL_RST;
        end else if (i_cfg_we) begin
            unique case (cpsc_pkg::t_cfg_reg'(i_cfg_idx))
                cpsc_pkg::REG_SITES: r_sites <= i_cfg_data[cpsc_pkg::SITES_W-1:0];
                cpsc_pkg::REG_NEG:   r_neg   <= $signed(i_cfg_data);
                cpsc_pkg::REG_POS:   r_pos   <= $signed(i_cfg_data);
                cpsc_pkg::REG_TOL:   r_tol   <= i_cfg_data[cpsc_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lp_vld  <= 1'b0;
            r_chk_vld <= 1'b0;
            r_hp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_lp_vld  <= (r_state == S_LP);
            r_chk_vld <= r_lp_vld && r_lp_last;
            r_hp_vld  <= (r_state == S_HOP);
            r_out_vld <= (r_state == S_DONE);

            if (r_lp_vld) begin
                r_acc    <= r_lp_last ? '0 : lp_sum;
                r_energy <= e_sum;
                if (r_lp_last) begin
                    r_chk_i   <= r_lp_i;
                    r_chk_v   <= lp_sum;
                end
            end
            if (r_chk_vld && !chk_good) begin
                r_states <= 1'b0;
            end
            if (r_hp_vld && hp_fail) begin
                r_hops <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_req.action == cpsc_pkg::ACT_EVAL) begin
                        r_codes  <= i_req.charge_codes;
                        r_n      <= n_start;
                        r_ci     <= '0;
                        r_cj     <= '0;
                        r_acc    <= '0;
                        r_energy <= '0;
                        r_states <= 1'b1;
                        r_hops   <= 1'b1;
                        r_state  <= (n_start == '0) ? S_DONE : S_LP;
                    end
                end
                S_LP: begin
                    r_lp_i    <= r_ci;
                    r_lp_j    <= r_cj;
                    r_lp_last <= cj_last;
                    if (cj_last) begin
                        r_cj <= '0;
                        if (ci_last) begin
                            r_state <= S_LP_DRAIN;
                        end else begin
                            r_ci <= r_ci + SITE_W'(1);
                        end
                    end else begin
                        r_cj <= r_cj + SITE_W'(1);
                    end
                end
                S_LP_DRAIN: begin
                    if (!r_lp_vld && !r_chk_vld) begin
                        r_ci    <= '0;
                        r_cj    <= '0;
                        r_state <= S_HOP_ROW;
                    end
                end
                S_HOP_ROW: begin
                    r_state <= S_HOP_LATCH;
                end
                S_HOP_LATCH: begin
                    r_vi    <= $signed(lp_rdata);
                    r_state <= S_HOP;
                end
                S_HOP: begin
                    r_hp_i   <= r_ci;
                    r_hp_j   <= r_cj;
                    if (cj_last) begin
                        r_cj <= '0;
                        if (ci_last) begin
                            r_state <= S_HOP_DRAIN;
                        end else begin
                            r_ci    <= r_ci + SITE_W'(1);
                            r_state <= S_HOP_ROW;
                        end
                    end else begin
                        r_cj <= r_cj + SITE_W'(1);
                    end
                end
                S_HOP_DRAIN: begin
                    if (!r_hp_vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_result.states_ok        <= r_states;
                    r_result.hop_stable       <= r_hops;
                    r_result.population_valid <= r_states && r_hops;
                    r_result.pair_energy      <= r_energy;
                    r_state                   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_result       = r_result;

    `CPSC_ASSERT_NOW(a_valid_join, i_clk, i_rst_n, o_result_valid,
        o_result.population_valid == (o_result.states_ok && o_result.hop_stable))
    `CPSC_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n,
        i_start && !o_busy && i_req.action == cpsc_pkg::ACT_EVAL, o_busy)
    `CPSC_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE,
        !r_lp_vld && !r_hp_vld && !r_chk_vld)
    `CPSC_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid)

endmodule
